// File: src/fused_lasso_tridiagonal_weights_macros.svh
// Assertion helpers for the fused lasso weight block.
`ifndef FUSED_LASSO_TRIDIAGONAL_WEIGHTS_MACROS_SVH
`define FUSED_LASSO_TRIDIAGONAL_WEIGHTS_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FLTW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fltw assertion failed");
// next-cycle implication
`define FLTW_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fltw assertion failed");
`else
`define FLTW_ASSERT_IMP(label, clk, rst, ante, cons)
`define FLTW_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/fltw_pkg.sv
`timescale 1ns / 1ps
package fltw_pkg;

  localparam int unsigned DIVW = 48;

  localparam logic [1:0] REG_LAMBDA_LEVEL  = 2'd0;
  localparam logic [1:0] REG_LAMBDA_FUSION = 2'd1;
  localparam logic [1:0] REG_EPSILON       = 2'd2;

  localparam logic KIND_MAIN = 1'b0;
  localparam logic KIND_OFF  = 1'b1;

  localparam logic [47:0] WPOS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] WNEG_MAG = 48'h8000_0000_0000;
  localparam logic [62:0] SUM_MAX  = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] coef;
    logic [31:0]        mag;
    logic               fin;
  } item_t;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_DIV_OFF   = 10'b00_0000_0010,
    ST_DIV_LEV   = 10'b00_0000_0100,
    ST_TERM_LEV  = 10'b00_0000_1000,
    ST_TERM_OFF  = 10'b00_0001_0000,
    ST_EMIT_OFF  = 10'b00_0010_0000,
    ST_EMIT_MAIN = 10'b00_0100_0000,
    ST_DIV_FIN   = 10'b00_1000_0000,
    ST_TERM_FIN  = 10'b01_0000_0000,
    ST_EMIT_FIN  = 10'b10_0000_0000
  } state_t;

endpackage

// File: src/fltw_front.sv
`timescale 1ns / 1ps
module fltw_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  coefficient,
  input  logic                final_element,
  output logic                push,
  output fltw_pkg::item_t     push_item,
  input  logic                full
);

  logic            held;
  fltw_pkg::item_t item;

  assign in_ready  = !held || !full;
  assign push      = held;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (held && !full) begin
      held <= 1'b0;
    end
  end

  // magnitude taken here so the level divisions and terms use an unsigned operand
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.coef <= coefficient;
      item.mag  <= coefficient[31] ? (~coefficient + 32'd1) : coefficient;
      item.fin  <= final_element;
    end
  end

endmodule

// File: src/fltw_fifo.sv
`timescale 1ns / 1ps
module fltw_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fltw_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output fltw_pkg::item_t pop_item,
  output logic            nonempty
);

  fltw_pkg::item_t mem [2];
  logic            wp;
  logic            rp;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_item;
  end

endmodule

// File: src/fltw_div.sv
`timescale 1ns / 1ps
module fltw_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [47:0] dvd;
  logic [32:0] dsr;
  logic [33:0] trial;
  logic        ge;

  // restoring, one quotient bit a cycle; zero divisor yields all ones
  assign trial    = {rem, dvd[47]};
  assign ge       = trial >= {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(fltw_pkg::DIVW);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? 33'(trial - {1'b0, dsr}) : trial[32:0];
      dvd <= {dvd[46:0], ge};
    end
  end

endmodule

// File: src/fltw_back.sv
`timescale 1ns / 1ps
`include "fused_lasso_tridiagonal_weights_macros.svh"
module fltw_back #(
  parameter int MAX_LENGTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        lambda_level,
  input  logic [31:0]        lambda_fusion,
  input  logic [15:0]        epsilon,
  input  logic               q_nonempty,
  input  fltw_pkg::item_t    q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               weight_kind,
  output logic [11:0]        position,
  output logic signed [47:0] weight_value,
  output logic [62:0]        penalty_sum,
  output logic               run_end
);

  localparam int IDXW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  fltw_pkg::state_t st;

  logic signed [31:0] a;
  logic [31:0]        amag;
  logic [31:0]        bcoef;
  logic [31:0]        bmag;
  logic               fin;
  logic [31:0]        ad;
  logic [47:0]        offmag;
  logic [47:0]        lev;
  logic signed [47:0] prev_off;
  logic [IDXW-1:0]    idx;
  logic               have_prev;
  logic [62:0]        acc;

  logic               dstarted;
  logic               div_start;
  logic               div_done;
  logic [47:0]        div_q;
  logic [47:0]        div_dvd;
  logic [32:0]        div_dsr;
  logic [47:0]        q_lev;
  logic [47:0]        q_off;

  logic [31:0]        tx;
  logic [47:0]        tw;
  logic [3:0]         tcnt;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        prod;
  logic [47:0]        tq;
  logic [79:0]        thi;
  logic [63:0]        tlo;
  logic [62:0]        tterm;
  logic [62:0]        hisat;
  logic [63:0]        tsum;
  logic [63:0]        asum;
  logic               term_last;

  logic [32:0]        diff;
  logic [32:0]        diff_abs;
  logic               out_free;
  logic               emit_now;
  logic [49:0]        mw_mid;
  logic [49:0]        mw_fin;
  logic [IDXW-1:0]    idx_next;

  assign out_free  = !out_valid || out_ready;
  assign emit_now  = out_free && ((st == fltw_pkg::ST_EMIT_OFF) ||
                     (st == fltw_pkg::ST_EMIT_MAIN) || (st == fltw_pkg::ST_EMIT_FIN));
  assign q_pop     = (st == fltw_pkg::ST_IDLE) && q_nonempty;
  assign term_last = (tcnt == 4'd8);

  assign diff     = {q_item.coef[31], q_item.coef} - {a[31], a};
  assign diff_abs = diff[32] ? (~diff + 33'd1) : diff;

  assign idx_next = (idx == IDXW'(MAX_LENGTH - 1)) ? '0 : idx + 1'b1;

  // ---- shared divider
  always_comb begin
    div_dvd = {lambda_level, 16'd0};
    div_dsr = {1'b0, bmag} + 33'(epsilon);
    case (st)
      fltw_pkg::ST_DIV_OFF: begin
        div_dvd = {lambda_fusion, 16'd0};
        div_dsr = {1'b0, ad} + 33'(epsilon);
      end
      fltw_pkg::ST_DIV_LEV: div_dsr = {1'b0, amag} + 33'(epsilon);
      default: ;
    endcase
  end

  assign div_start = !dstarted && ((st == fltw_pkg::ST_DIV_OFF) ||
                     (st == fltw_pkg::ST_DIV_LEV) || (st == fltw_pkg::ST_DIV_FIN));
  assign q_lev = (div_q > fltw_pkg::WPOS_MAX) ? fltw_pkg::WPOS_MAX : div_q;
  assign q_off = (div_q > fltw_pkg::WNEG_MAG) ? fltw_pkg::WNEG_MAG : div_q;

  fltw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---- term engine: w * (x*x >> 16) >> 16 through one 32x32 multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (tcnt)
      4'd0: begin mul_a = tx;                mul_b = tx;                end
      4'd2: begin mul_a = tw[47:16];         mul_b = tq[31:0];          end
      4'd3: begin mul_a = tw[47:16];         mul_b = {16'd0, tq[47:32]}; end
      4'd4: begin mul_a = {16'd0, tw[15:0]}; mul_b = tq[31:0];          end
      4'd5: begin mul_a = {16'd0, tw[15:0]}; mul_b = {16'd0, tq[47:32]}; end
      default: ;
    endcase
  end

  assign hisat = (thi > 80'(fltw_pkg::SUM_MAX)) ? fltw_pkg::SUM_MAX : thi[62:0];
  assign tsum  = {1'b0, hisat} + {16'd0, tlo[63:16]};
  assign asum  = {1'b0, acc} + {1'b0, tterm};

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (tcnt)
      4'd1: tq  <= prod[63:16];
      4'd3: thi <= 80'(prod);
      4'd4: thi <= thi + (80'(prod) << 32);
      4'd5: tlo <= prod;
      4'd6: tlo <= tlo + (prod << 32);
      4'd7: tterm <= (tsum > 64'(fltw_pkg::SUM_MAX)) ? fltw_pkg::SUM_MAX : tsum[62:0];
      default: ;
    endcase
  end

  // main weights, never negative, clipped at the top
  assign mw_mid = {2'b00, lev} - {{2{prev_off[47]}}, prev_off} + {2'b00, offmag};
  assign mw_fin = {2'b00, lev} - {{2{prev_off[47]}}, prev_off};

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= fltw_pkg::ST_IDLE;
      dstarted  <= 1'b0;
      tcnt      <= '0;
      have_prev <= 1'b0;
      idx       <= '0;
      acc       <= '0;
      prev_off  <= '0;
      a         <= '0;
      amag      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !emit_now) out_valid <= 1'b0;
      if (div_start) dstarted <= 1'b1;
      if ((st == fltw_pkg::ST_TERM_LEV) || (st == fltw_pkg::ST_TERM_OFF) ||
          (st == fltw_pkg::ST_TERM_FIN)) begin
        tcnt <= term_last ? 4'd0 : tcnt + 4'd1;
        if (term_last) acc <= (asum > 64'(fltw_pkg::SUM_MAX)) ? fltw_pkg::SUM_MAX
                                                               : asum[62:0];
      end
      case (st)
        fltw_pkg::ST_IDLE: begin
          if (q_nonempty) begin
            bcoef <= q_item.coef;
            bmag  <= q_item.mag;
            fin   <= q_item.fin;
            ad    <= diff_abs[31:0];
            if (have_prev) begin
              st <= fltw_pkg::ST_DIV_OFF;
            end else begin
              prev_off <= '0;
              if (q_item.fin) begin
                st <= fltw_pkg::ST_DIV_FIN;
              end else begin
                a         <= q_item.coef;
                amag      <= q_item.mag;
                have_prev <= 1'b1;
              end
            end
          end
        end
        fltw_pkg::ST_DIV_OFF: begin
          if (div_done) begin
            offmag   <= q_off;
            dstarted <= 1'b0;
            st       <= fltw_pkg::ST_DIV_LEV;
          end
        end
        fltw_pkg::ST_DIV_LEV: begin
          if (div_done) begin
            lev      <= q_lev;
            tw       <= q_lev;
            tx       <= amag;
            dstarted <= 1'b0;
            st       <= fltw_pkg::ST_TERM_LEV;
          end
        end
        fltw_pkg::ST_TERM_LEV: begin
          if (term_last) begin
            tw <= offmag;
            tx <= ad;
            st <= fltw_pkg::ST_TERM_OFF;
          end
        end
        fltw_pkg::ST_TERM_OFF: begin
          if (term_last) st <= fltw_pkg::ST_EMIT_OFF;
        end
        fltw_pkg::ST_EMIT_OFF: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            weight_kind  <= fltw_pkg::KIND_OFF;
            position     <= 12'(idx);
            weight_value <= -offmag;
            penalty_sum  <= acc;
            run_end      <= 1'b0;
            st           <= fltw_pkg::ST_EMIT_MAIN;
          end
        end
        fltw_pkg::ST_EMIT_MAIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            weight_kind  <= fltw_pkg::KIND_MAIN;
            position     <= 12'(idx);
            weight_value <= (mw_mid > 50'(fltw_pkg::WPOS_MAX)) ? fltw_pkg::WPOS_MAX
                                                                 : mw_mid[47:0];
            penalty_sum  <= acc;
            run_end      <= 1'b0;
            prev_off     <= -offmag;
            idx          <= idx_next;
            if (fin) begin
              st <= fltw_pkg::ST_DIV_FIN;
            end else begin
              a    <= bcoef;
              amag <= bmag;
              st   <= fltw_pkg::ST_IDLE;
            end
          end
        end
        fltw_pkg::ST_DIV_FIN: begin
          if (div_done) begin
            lev      <= q_lev;
            tw       <= q_lev;
            tx       <= bmag;
            dstarted <= 1'b0;
            st       <= fltw_pkg::ST_TERM_FIN;
          end
        end
        fltw_pkg::ST_TERM_FIN: begin
          if (term_last) st <= fltw_pkg::ST_EMIT_FIN;
        end
        fltw_pkg::ST_EMIT_FIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            weight_kind  <= fltw_pkg::KIND_MAIN;
            position     <= 12'(idx);
            weight_value <= (mw_fin > 50'(fltw_pkg::WPOS_MAX)) ? fltw_pkg::WPOS_MAX
                                                                 : mw_fin[47:0];
            penalty_sum  <= acc;
            run_end      <= 1'b1;
            // run state back to zero for the next vector
            a            <= '0;
            amag         <= '0;
            prev_off     <= '0;
            idx          <= '0;
            have_prev    <= 1'b0;
            acc          <= '0;
            st           <= fltw_pkg::ST_IDLE;
          end
        end
        default: st <= fltw_pkg::ST_IDLE;
      endcase
    end
  end

  `FLTW_ASSERT_IMP(a_end_is_main, clk, rst, out_valid && run_end,
                   weight_kind == fltw_pkg::KIND_MAIN)
  `FLTW_ASSERT_IMP(a_main_nonneg, clk, rst,
                   out_valid && (weight_kind == fltw_pkg::KIND_MAIN), !weight_value[47])
  `FLTW_ASSERT_IMP(a_off_nonpos, clk, rst,
                   out_valid && (weight_kind == fltw_pkg::KIND_OFF),
                   weight_value[47] || (weight_value == '0))
  `FLTW_ASSERT_NXT(a_run_cleared, clk, rst,
                   (st == fltw_pkg::ST_EMIT_FIN) && out_free,
                   (acc == '0) && !have_prev && (idx == '0))

endmodule

// File: src/fused_lasso_tridiagonal_weights.sv
`timescale 1ns / 1ps
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    coefficient, final_element
// out      output     out_valid/out_ready  weight_kind, position, weight_value,
//                                          penalty_sum, run_end
// cfg      input      cfg_we (no wait)     cfg_index, cfg_data
//
// Sequence: the first coefficient of a vector, unless it is also the final one,
// is only stored. Every later one goes through the sequencer as a pop, two 48-bit
// restoring divisions (one shared divider), two passes through the shared 32x32
// multiplier for the quadratic form, and two results. The final coefficient adds
// its own level division, term and result. The divider sets the pace.
// Reset: synchronous, clears the run state and loads the register defaults.
// Stalls: a two-entry queue sits between input register and sequencer; the
// sequencer holds in a result state while the output register is full.
module fused_lasso_tridiagonal_weights #(
  parameter int MAX_LENGTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] coefficient,
  input  logic               final_element,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               weight_kind,
  output logic [11:0]        position,
  output logic signed [47:0] weight_value,
  output logic [62:0]        penalty_sum,
  output logic               run_end,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // configuration registers; index 3 is ignored
  logic [31:0] lambda_level;
  logic [31:0] lambda_fusion;
  logic [15:0] epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_level  <= 32'h0001_0000;
      lambda_fusion <= 32'h0001_0000;
      epsilon       <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        fltw_pkg::REG_LAMBDA_LEVEL:  lambda_level  <= cfg_data;
        fltw_pkg::REG_LAMBDA_FUSION: lambda_fusion <= cfg_data;
        fltw_pkg::REG_EPSILON:       epsilon       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // front: input register, magnitude of each coefficient
  logic            push;
  fltw_pkg::item_t push_item;
  logic            full;

  fltw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .coefficient   (coefficient),
    .final_element (final_element),
    .push          (push),
    .push_item     (push_item),
    .full          (full)
  );

  // queue decoupling front from the sequencer
  logic            q_pop;
  fltw_pkg::item_t q_item;
  logic            q_nonempty;

  fltw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .nonempty  (q_nonempty)
  );

  // back: divider, multiplier and result sequencing
  fltw_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .lambda_level  (lambda_level),
    .lambda_fusion (lambda_fusion),
    .epsilon       (epsilon),
    .q_nonempty    (q_nonempty),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .weight_kind   (weight_kind),
    .position      (position),
    .weight_value  (weight_value),
    .penalty_sum   (penalty_sum),
    .run_end       (run_end)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  // index with no register behind it
  localparam logic [1:0] REG_NONE = 2'd3;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  // input channel
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] coefficient = '0;
  logic               final_element = 1'b0;
  // output channel
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               weight_kind;
  logic [11:0]        position;
  logic signed [47:0] weight_value;
  logic [62:0]        penalty_sum;
  logic               run_end;
  // register write port
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  fused_lasso_tridiagonal_weights DUT (.*);

  typedef struct {
    logic        kind;
    logic [11:0] pos;
    logic [47:0] wval;
    logic [62:0] psum;
    logic        last;
  } weight_t;

  weight_t expected_weights[$];
  int errors = 0;

  // shadow of the block's registers
  logic [31:0] lam_lev, lam_fus;
  logic [15:0] eps;
  // shadow of the run state
  logic signed [31:0] prev_coef;
  logic signed [47:0] prev_off;
  logic [11:0]        row;
  logic               have_prev;
  logic [62:0]        acc;

  // receiver hold-off control
  int  hold_cycles = 0;
  bit  no_idle = 1'b0;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {2'b0, fltw_pkg::SUM_MAX}) ? {1'b0, fltw_pkg::SUM_MAX} : s[63:0];
  endfunction

  // floor((lam<<16)/den), capped; den == 0 gives the cap
  function automatic logic [63:0] quot(logic [31:0] lam, logic [63:0] den,
                                       logic [63:0] cap);
    logic [63:0] q;
    if (den == 0) return cap;
    q = {16'b0, lam, 16'b0} / den;
    return (q > cap) ? cap : q;
  endfunction

  // weight (Q32.16) times square (Q32.32) into Q47.16, saturating
  function automatic logic [63:0] qterm(logic [63:0] w, logic [63:0] sq);
    logic [63:0]  q, lo;
    logic [127:0] hi;
    q  = sq >> 16;
    lo = ({48'b0, w[15:0]} * q) >> 16;
    hi = {64'b0, w >> 16} * {64'b0, q};
    if (hi > {65'b0, fltw_pkg::SUM_MAX}) return {1'b0, fltw_pkg::SUM_MAX};
    return sat_add(hi[63:0], lo);
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [47:0] clip_main(logic signed [63:0] v);
    return (v > $signed({16'b0, fltw_pkg::WPOS_MAX})) ? fltw_pkg::WPOS_MAX : v[47:0];
  endfunction

  task automatic reset_run();
    prev_coef = '0; prev_off = '0; row = '0; have_prev = 1'b0; acc = '0;
  endtask

  task automatic push_weight(logic kind, logic [11:0] pos, logic [47:0] w,
                             logic last);
    weight_t e;
    e.kind = kind; e.pos = pos; e.wval = w; e.psum = acc; e.last = last;
    expected_weights.push_back(e);
  endtask

  // predicts the weights that one coefficient releases
  task automatic predict_weights(logic signed [31:0] c, logic fin);
    logic [63:0]        ad, offmag, lev, a2;
    logic signed [63:0] off, mainw;
    logic [11:0]        nrow;
    nrow = row;
    if (have_prev) begin
      ad     = mag(64'(c) - 64'(prev_coef));
      offmag = quot(lam_fus, ad + eps, {16'b0, fltw_pkg::WNEG_MAG});
      off    = -$signed(offmag);
      a2     = mag(64'(prev_coef));
      lev    = quot(lam_lev, a2 + eps, {16'b0, fltw_pkg::WPOS_MAX});
      mainw  = $signed(lev) - 64'(prev_off) - off;
      acc    = 63'(sat_add(64'(acc), qterm(lev, a2 * a2)));
      acc    = 63'(sat_add(64'(acc), qterm(offmag, ad * ad)));
      push_weight(fltw_pkg::KIND_OFF, row, off[47:0], 1'b0);
      push_weight(fltw_pkg::KIND_MAIN, row, clip_main(mainw), 1'b0);
      nrow     = row + 12'd1;   // 12-bit wrap matches MAX_LENGTH
      prev_off = off[47:0];
    end else begin
      prev_off = '0;
    end
    if (fin) begin
      a2  = mag(64'(c));
      lev = quot(lam_lev, a2 + eps, {16'b0, fltw_pkg::WPOS_MAX});
      acc = 63'(sat_add(64'(acc), qterm(lev, a2 * a2)));
      push_weight(fltw_pkg::KIND_MAIN, nrow, clip_main($signed(lev) - 64'(prev_off)),
                  1'b1);
      reset_run();
    end else begin
      prev_coef = c; have_prev = 1'b1; row = nrow;
    end
  endtask

  // register write; only while nothing is in flight
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      fltw_pkg::REG_LAMBDA_LEVEL:  lam_lev = val;
      fltw_pkg::REG_LAMBDA_FUSION: lam_fus = val;
      fltw_pkg::REG_EPSILON:       eps = val[15:0];
      default: ;
    endcase
  endtask

  // offers one item at a falling edge; the predictor runs when it is taken
  task automatic send_item(logic signed [31:0] c, logic fin, bit may_idle);
    while (may_idle && !no_idle && $urandom_range(99) < 23) @(negedge clk);
    in_valid = 1'b1; coefficient = c; final_element = fin;
    // in_ready is registered logic, stable between edges
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    predict_weights(c, fin);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // waits for the queue to drain, then covers a first item still in the sequencer
  task automatic drain();
    while (expected_weights.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off when asked
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 23);
    end
  end

  // checker: compare each taken item against the oldest expectation
  always @(posedge clk) begin
    weight_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_weights.size() == 0) begin
        $error("unexpected result item kind=%0d pos=%0d", weight_kind, position);
        errors++;
      end else begin
        e = expected_weights.pop_front();
        if (weight_kind !== e.kind) begin
          $error("weight_kind exp %0d got %0d", e.kind, weight_kind); errors++;
        end
        if (position !== e.pos) begin
          $error("position exp %0d got %0d", e.pos, position); errors++;
        end
        if (weight_value !== e.wval) begin
          $error("weight_value exp %0d got %0d", $signed(e.wval), weight_value);
          errors++;
        end
        if (penalty_sum !== e.psum) begin
          $error("penalty_sum exp %0d got %0d", e.psum, penalty_sum); errors++;
        end
        if (run_end !== e.last) begin
          $error("run_end exp %0d got %0d", e.last, run_end); errors++;
        end
      end
    end
  end

  // directed table; exp_w holds a typed-in single weight for length-one vectors
  typedef struct {
    logic signed [31:0] c;
    logic               fin;
    bit                 has_exp;
    logic [47:0]        exp_w;
  } row_t;

  row_t directed[12] = '{
    // length one after reset: 1.0/(0+1 lsb) = 2^32 in Q32.16
    '{32'sd0, 1'b1, 1'b1, 48'h0001_0000_0000},
    // huge coefficient -> tiny weight: 2^32/2^31 and 2^32/(2^31+1)
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 48'h0000_0000_0002},
    '{32'h8000_0000, 1'b1, 1'b1, 48'h0000_0000_0001},
    // short vectors through the predictor
    '{32'sd65536, 1'b0, 1'b0, '0},
    '{-32'sd65536, 1'b0, 1'b0, '0},
    '{-32'sd65536, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b1, 1'b0, '0},
    '{32'sd1, 1'b0, 1'b0, '0},
    '{32'sd1, 1'b1, 1'b0, '0},
    '{32'h5555_AAAA, 1'b0, 1'b0, '0},
    '{32'hAAAA_5555, 1'b1, 1'b0, '0}
  };

  task automatic random_vector(int len);
    logic signed [31:0] c;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(3))
        0: c = $urandom;
        1: c = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        2: c = (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: c = $signed($urandom_range(0, 255)) - 128;
      endcase
      send_item(c, k == len - 1, 1'b1);
    end
  endtask

  initial begin
    int sent;
    lam_lev = 32'd65536; lam_fus = 32'd65536; eps = 16'd1;
    reset_run();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    foreach (directed[i]) begin
      send_item(directed[i].c, directed[i].fin, 1'b0);
      if (directed[i].has_exp)
        expected_weights[$].wval = directed[i].exp_w;
    end
    drain();

    // epsilon 0 shows the saturating quotient; extremes of the lambdas
    write_reg(fltw_pkg::REG_EPSILON, 32'd0);
    write_reg(fltw_pkg::REG_LAMBDA_LEVEL, 32'hFFFF_FFFF);
    write_reg(fltw_pkg::REG_LAMBDA_FUSION, 32'hFFFF_FFFF);
    send_item(32'sd0, 1'b0, 1'b0);
    send_item(32'sd0, 1'b0, 1'b0);
    send_item(32'sd5, 1'b1, 1'b0);
    drain();
    write_reg(REG_NONE, 32'hFFFF_FFFF);   // out-of-range index, ignored
    write_reg(fltw_pkg::REG_LAMBDA_LEVEL, 32'd0);
    write_reg(fltw_pkg::REG_LAMBDA_FUSION, 32'd0);
    write_reg(fltw_pkg::REG_EPSILON, 32'h0000_FFFF);
    send_item(32'sd100, 1'b0, 1'b0);
    send_item(-32'sd100, 1'b1, 1'b0);
    drain();

    // random part, several register settings
    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(fltw_pkg::REG_LAMBDA_LEVEL, phase == 3 ? 32'hFFFF_FFFF : $urandom);
      write_reg(fltw_pkg::REG_LAMBDA_FUSION, phase == 0 ? 32'd0 : $urandom);
      write_reg(fltw_pkg::REG_EPSILON, phase == 2 ? 32'd1 : $urandom_range(1, 65535));
      if (phase == 1) begin
        // long receiver hold-off while the sender keeps offering items
        hold_cycles = 2000;
        random_vector(8);
        sent += 8;
      end
      if (phase == 2) no_idle = 1'b1;
      while (sent < 34 * (phase + 1)) begin
        int len;
        len = $urandom_range(1, 6);
        random_vector(len);
        sent += len;
      end
      no_idle = 1'b0;
      drain();   // sender pauses until every result is back
    end

    if (errors == 0) begin
      $display("PASS fused_lasso_tridiagonal_weights");
    end else begin
      $display("FAIL fused_lasso_tridiagonal_weights");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL fused_lasso_tridiagonal_weights");
    $finish;
  end

endmodule
